// ----- hw/rtl/dpbp_pkg.sv -----
`timescale 1ns / 1ps
package dpbp_pkg;
   localparam int unsigned DivWidth = 51;
   localparam int unsigned DivSteps = 51;
   localparam logic [20:0] CountMax = 21'h1FFFFF;

   localparam logic [2:0] RegWidth   = 3'd0;
   localparam logic [2:0] RegHeight  = 3'd1;
   localparam logic [2:0] RegFocalX  = 3'd2;
   localparam logic [2:0] RegFocalY  = 3'd3;
   localparam logic [2:0] RegCenterX = 3'd4;
   localparam logic [2:0] RegCenterY = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAY,
      ST_DIV,
      ST_NEXT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic ray;
      logic div_start;
      logic div_step;
      logic div_store;
      logic finish;
      logic [1:0] coord;
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic div_done;
   } status_type;
endpackage

// ----- hw/rtl/depth_pixel_back_projection_top.sv -----
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// req       req_valid/req_stall    inverse depth, variance, intensity, gradients
// rsp       rsp_valid/rsp_stall    keep, point x/y/z, pass-through, index, count
// csr       psel/penable/pready    six registers at byte address 4*i
// One pixel at a time: a dropped pixel passes the accept, ray and result states; a kept
// one also runs three 51-step divides on the shared radix-2 divider, each ending with
// a store and a next state, to form X, Y and Z in turn.
// Synchronous reset clears counters and the controller; registers take defaults.
// A stalled result holds its payload; no new transaction is taken meanwhile.
module depth_pixel_back_projection_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_inverse_depth,
   input  logic signed [23:0] req_depth_variance,
   input  logic [15:0]        req_pixel_intensity,
   input  logic signed [15:0] req_gradient_x,
   input  logic signed [15:0] req_gradient_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_keep,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic signed [15:0] rsp_out_gradient_x,
   output logic signed [15:0] rsp_out_gradient_y,
   output logic [15:0]        rsp_out_intensity,
   output logic signed [23:0] rsp_out_variance,
   output logic [19:0]        rsp_pixel_index,
   output logic               rsp_frame_end,
   output logic [20:0]        rsp_point_count,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   logic [10:0] width_ff, height_ff;
   logic [31:0] fx_ff, fy_ff, cx_ff, cy_ff;
   logic wr;
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd640;
         height_ff <= 11'd480;
         fx_ff <= '0;
         fy_ff <= '0;
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (wr) begin
         unique case (csr_paddr[4:2])
            dpbp_pkg::RegWidth:   width_ff <= csr_pwdata[10:0];
            dpbp_pkg::RegHeight:  height_ff <= csr_pwdata[10:0];
            dpbp_pkg::RegFocalX:  fx_ff <= csr_pwdata;
            dpbp_pkg::RegFocalY:  fy_ff <= csr_pwdata;
            dpbp_pkg::RegCenterX: cx_ff <= csr_pwdata;
            dpbp_pkg::RegCenterY: cy_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         dpbp_pkg::RegWidth:   csr_prdata = {21'd0, width_ff};
         dpbp_pkg::RegHeight:  csr_prdata = {21'd0, height_ff};
         dpbp_pkg::RegFocalX:  csr_prdata = fx_ff;
         dpbp_pkg::RegFocalY:  csr_prdata = fy_ff;
         dpbp_pkg::RegCenterX: csr_prdata = cx_ff;
         dpbp_pkg::RegCenterY: csr_prdata = cy_ff;
         default: csr_prdata = '0;
      endcase
   end

   dpbp_pkg::cmd_type cmd;
   dpbp_pkg::status_type status;

   dpbp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd)
   );

   dpbp_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .cfg_width(width_ff), .cfg_height(height_ff),
      .cfg_fx(fx_ff), .cfg_fy(fy_ff), .cfg_cx(cx_ff), .cfg_cy(cy_ff),
      .req_inverse_depth(req_inverse_depth), .req_depth_variance(req_depth_variance),
      .req_pixel_intensity(req_pixel_intensity), .req_gradient_x(req_gradient_x),
      .req_gradient_y(req_gradient_y), .rsp_keep(rsp_keep),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .rsp_out_gradient_x(rsp_out_gradient_x), .rsp_out_gradient_y(rsp_out_gradient_y),
      .rsp_out_intensity(rsp_out_intensity), .rsp_out_variance(rsp_out_variance),
      .rsp_pixel_index(rsp_pixel_index), .rsp_frame_end(rsp_frame_end),
      .rsp_point_count(rsp_point_count)
   );
endmodule

// ----- hw/rtl/dpbp_ctrl.sv -----
`timescale 1ns / 1ps
module dpbp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  dpbp_pkg::status_type status,
   output dpbp_pkg::cmd_type   cmd
);
   dpbp_pkg::state_type state_ff, state_in;
   logic [1:0] coord_ff, coord_in;

   always_comb begin
      state_in = state_ff;
      coord_in = coord_ff;
      unique case (state_ff)
         dpbp_pkg::ST_IDLE: if (req_valid) state_in = dpbp_pkg::ST_RAY;
         dpbp_pkg::ST_RAY: begin
            coord_in = 2'd0;
            state_in = status.keep ? dpbp_pkg::ST_DIV : dpbp_pkg::ST_OUT;
         end
         dpbp_pkg::ST_DIV: if (status.div_done) state_in = dpbp_pkg::ST_NEXT;
         dpbp_pkg::ST_NEXT: begin
            if (coord_ff == 2'd2) begin
               state_in = dpbp_pkg::ST_OUT;
            end else begin
               coord_in = coord_ff + 2'd1;
               state_in = dpbp_pkg::ST_DIV;
            end
         end
         dpbp_pkg::ST_OUT: if (!rsp_stall) state_in = dpbp_pkg::ST_IDLE;
         default: state_in = dpbp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.coord = coord_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         dpbp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         dpbp_pkg::ST_RAY: begin
            cmd.ray = 1'b1;
            cmd.div_start = status.keep;
            cmd.coord = 2'd0;
         end
         dpbp_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_store = status.div_done;
         end
         dpbp_pkg::ST_NEXT: begin
            cmd.div_start = (coord_ff != 2'd2);
            cmd.coord = coord_ff + 2'd1;
         end
         dpbp_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.finish = !rsp_stall;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpbp_pkg::ST_IDLE;
         coord_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         coord_ff <= coord_in;
      end
   end
endmodule

// ----- hw/rtl/dpbp_datapath.sv -----
`timescale 1ns / 1ps
module dpbp_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dpbp_pkg::cmd_type    cmd,
   output dpbp_pkg::status_type status,
   input  logic [10:0]          cfg_width,
   input  logic [10:0]          cfg_height,
   input  logic signed [31:0]   cfg_fx,
   input  logic signed [31:0]   cfg_fy,
   input  logic signed [31:0]   cfg_cx,
   input  logic signed [31:0]   cfg_cy,
   input  logic signed [23:0]   req_inverse_depth,
   input  logic signed [23:0]   req_depth_variance,
   input  logic [15:0]          req_pixel_intensity,
   input  logic signed [15:0]   req_gradient_x,
   input  logic signed [15:0]   req_gradient_y,
   output logic                 rsp_keep,
   output logic signed [31:0]   rsp_point_x,
   output logic signed [31:0]   rsp_point_y,
   output logic signed [31:0]   rsp_point_z,
   output logic signed [15:0]   rsp_out_gradient_x,
   output logic signed [15:0]   rsp_out_gradient_y,
   output logic [15:0]          rsp_out_intensity,
   output logic signed [23:0]   rsp_out_variance,
   output logic [19:0]          rsp_pixel_index,
   output logic                 rsp_frame_end,
   output logic [20:0]          rsp_point_count
);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int CH = $clog2(MAX_HEIGHT + 1);
   localparam int DW = (CW > CH ? CW : CH) + 1;
   localparam int NW = dpbp_pkg::DivWidth;
   localparam int SW = $clog2(dpbp_pkg::DivSteps + 1);

   logic [DW-1:0] w_use, h_use;
   logic [DW-1:0] x_ff, y_ff, x_in, y_in;
   logic [20:0] kept_ff, kept_in;
   logic [DW-1:0] xs_ff, ys_ff;
   logic signed [23:0] id_ff, var_ff;
   logic [15:0] int_ff;
   logic signed [15:0] gx_ff, gy_ff;
   logic signed [63:0] rx_ff, ry_ff;
   logic keep_ff, fend_ff;
   logic [19:0] idx_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [NW-1:0] rem_ff, quo_ff, num_ff;
   logic [23:0] den_ff;
   logic neg_ff;
   logic [SW-1:0] step_ff;

   always_comb begin
      w_use = DW'(cfg_width);
      h_use = DW'(cfg_height);
      if (cfg_width < 11'd3) w_use = DW'(3);
      else if ({1'b0, cfg_width} > 12'(MAX_WIDTH)) w_use = DW'(MAX_WIDTH);
      if (cfg_height < 11'd3) h_use = DW'(3);
      else if ({1'b0, cfg_height} > 12'(MAX_HEIGHT)) h_use = DW'(MAX_HEIGHT);
   end

   logic last_row, last_col, border;
   assign last_row = ys_ff >= h_use - DW'(1);
   assign last_col = xs_ff >= w_use - DW'(1);
   assign border = (xs_ff == '0) || last_col || (ys_ff == '0) || last_row;
   assign status.keep = !border && (var_ff > 0) && (id_ff != 0);
   assign status.div_done = (step_ff == SW'(dpbp_pkg::DivSteps));

   // ray numerator: ray*256, magnitude taken for the unsigned divider
   logic signed [63:0] ray_sel;
   logic [63:0] ray_mag;
   logic [23:0] id_mag;
   always_comb begin
      unique case (cmd.coord)
         2'd0: ray_sel = rx_ff;
         2'd1: ray_sel = ry_ff;
         default: ray_sel = 64'sd1 <<< 24;
      endcase
      ray_mag = ray_sel[63] ? 64'(-ray_sel) : 64'(ray_sel);
      id_mag = id_ff[23] ? 24'(-id_ff) : 24'(id_ff);
   end

   logic [NW:0] trial;
   assign trial = {rem_ff, num_ff[NW-1]} - {(NW-23)'(0), den_ff};

   logic signed [NW:0] q_signed;
   logic signed [31:0] q_sat;
   always_comb begin
      q_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (q_signed > $signed((NW+1)'(32'h7FFFFFFF))) q_sat = 32'sh7FFFFFFF;
      else if (q_signed < -$signed((NW+1)'(33'h080000000))) q_sat = 32'sh80000000;
      else q_sat = q_signed[31:0];
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      kept_in = kept_ff;
      if (cmd.ray) begin
         if (last_col && last_row) begin
            x_in = '0;
            y_in = '0;
         end else if (last_row) begin
            y_in = '0;
            x_in = xs_ff + DW'(1);
         end else begin
            y_in = ys_ff + DW'(1);
         end
         if (status.keep && kept_ff != dpbp_pkg::CountMax) kept_in = kept_ff + 21'd1;
      end
      if (cmd.finish && fend_ff) kept_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         kept_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         kept_ff <= kept_in;
      end
   end

   logic [31:0] idx_full;
   assign idx_full = 32'(xs_ff) + 32'(ys_ff) * 32'(w_use);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xs_ff <= x_ff;
         ys_ff <= y_ff;
         id_ff <= req_inverse_depth;
         var_ff <= req_depth_variance;
         int_ff <= req_pixel_intensity;
         gx_ff <= req_gradient_x;
         gy_ff <= req_gradient_y;
         // rays are ready before the first divide starts
         rx_ff <= 64'(cfg_fx) * $signed({1'b0, x_ff}) + 64'(cfg_cx);
         ry_ff <= 64'(cfg_fy) * $signed({1'b0, y_ff}) + 64'(cfg_cy);
      end
      if (cmd.ray) begin
         keep_ff <= status.keep;
         fend_ff <= last_col && last_row;
         idx_ff <= idx_full[19:0];
         px_ff <= '0;
         py_ff <= '0;
         pz_ff <= '0;
      end
      if (cmd.div_start) begin
         // |fx*x+cx| < 2^43 for x below 4096, so ray*256 fits in 51 bits
         num_ff <= NW'(ray_mag << 8);
         den_ff <= id_mag;
         neg_ff <= ray_sel[63] ^ id_ff[23];
         rem_ff <= '0;
         quo_ff <= '0;
         step_ff <= '0;
      end else if (cmd.div_step && !status.div_done) begin
         num_ff <= num_ff << 1;
         if (!trial[NW]) begin
            rem_ff <= trial[NW-1:0];
            quo_ff <= {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[NW-2:0], num_ff[NW-1]};
            quo_ff <= {quo_ff[NW-2:0], 1'b0};
         end
         step_ff <= step_ff + SW'(1);
      end
      if (cmd.div_store) begin
         unique case (cmd.coord)
            2'd0: px_ff <= q_sat;
            2'd1: py_ff <= q_sat;
            default: pz_ff <= q_sat;
         endcase
      end
   end

   assign rsp_keep = keep_ff;
   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;
   assign rsp_point_z = pz_ff;
   assign rsp_out_gradient_x = gx_ff;
   assign rsp_out_gradient_y = gy_ff;
   assign rsp_out_intensity = int_ff;
   assign rsp_out_variance = var_ff;
   assign rsp_pixel_index = idx_ff;
   assign rsp_frame_end = fend_ff;
   assign rsp_point_count = kept_ff;
endmodule

// ----- hw/rtl/dpbp_checker.sv -----
`timescale 1ns / 1ps
module dpbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_keep,
   input logic [31:0] rsp_point_z,
   input logic [20:0] rsp_point_count
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result pending");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("block not busy after taking a transaction");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_z))
      else $error("stalled result changed");
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_keep |-> rsp_point_z == 32'd0)
      else $error("dropped pixel has a point");
   a_keep_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep |-> rsp_point_count != 21'd0)
      else $error("kept pixel not counted");
endmodule

bind depth_pixel_back_projection_top dpbp_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_keep(rsp_keep),
   .rsp_point_z(rsp_point_z), .rsp_point_count(rsp_point_count)
);
